/* hdl/rcpc_pkg.sv */
// Shared constants and field layout for the ray convex polyhedron clip block.
package rcpc_pkg;

    localparam int IN_BYTES_W  = 368;
    localparam int OUT_BYTES_W = 104;

    localparam int IDX_W  = 9;
    localparam int VEC_W  = 48;
    localparam int DIR_W  = 18;
    localparam int NRM_W  = 18;
    localparam int TOL_W  = 32;
    localparam int PLIM_W = 17;

    // Plane entry packs the three normal components and the offset.
    localparam int ENTRY_W = 3 * NRM_W + VEC_W;

    // Widths of the working values.
    localparam int ACC_W  = 52;
    localparam int D_W    = 54;
    localparam int W_W    = 38;
    localparam int UD_W   = 37;
    localparam int Q_W    = 49;
    localparam int NUM_W  = D_W + 32;
    localparam int CNT_W  = 7;

    localparam logic [Q_W-1:0] QUOT_CAP = Q_W'(1) << 47;

    // Command codes.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SHOOT = 2'd1;
    localparam logic [1:0] CMD_SHOOT_NEG = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_PAR_LIMIT = 1'b1;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [NRM_W-1:0] nrm_t;

endpackage

/* hdl/rcpc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rcpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/ray_convex_polyhedron_clip.sv */
// Top level of the ray clip against a convex polyhedron of half-space planes.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+----------------------------------
//  s_axis    | in        | tvalid / tready       | command item, 368-bit tdata
//  m_axis    | out       | tvalid / tready       | result item, 104-bit tdata
//  cfg       | in        | cfg_wr_en             | cfg_index, cfg_data (32 bits)
//
// A write or unused command goes straight to the finish state and offers its
// result once the output register is free. A shoot walks its plane range: each
// plane takes a range check, a table read, three multiply-accumulate steps, the
// plane test and the interval test, and a non-parallel plane adds the bit-serial
// divider and an update step; the divider sets the rate.
// Reset returns the control state to idle and sets both configuration registers
// to 66; the plane table is not cleared and holds nothing useful until written.
// The output register lets a new item be accepted while a result still waits;
// a second result stalls in the finish state until the first has gone.
module ray_convex_polyhedron_clip #(
    parameter int PLANE_COUNT = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cmd, first_index, last_index, vec_x, vec_y, vec_z, plane_offset,
    // dir_x, dir_y, dir_z, range_in, range_out (lowest bits first)
    input  logic [rcpc_pkg::IN_BYTES_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // hit, enter_dist, exit_dist (lowest bits first)
    output logic [rcpc_pkg::OUT_BYTES_W-1:0]  m_axis_tdata,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [rcpc_pkg::TOL_W-1:0]        cfg_data
);

    import rcpc_pkg::*;

    localparam int AW = $clog2(PLANE_COUNT);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_LOAD  = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_CHK   = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_UPD   = 4'd6;
    localparam logic [3:0] ST_TEST  = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    // Unpacked input fields.
    logic [1:0]        in_cmd;
    logic [IDX_W-1:0]  in_first;
    logic [IDX_W-1:0]  in_last;
    vec_t              in_vx;
    vec_t              in_vy;
    vec_t              in_vz;
    vec_t              in_off;
    nrm_t              in_dx;
    nrm_t              in_dy;
    nrm_t              in_dz;
    vec_t              in_rin;
    vec_t              in_rout;

    assign in_cmd   = s_axis_tdata[1:0];
    assign in_first = s_axis_tdata[10:2];
    assign in_last  = s_axis_tdata[19:11];
    assign in_vx    = s_axis_tdata[67:20];
    assign in_vy    = s_axis_tdata[115:68];
    assign in_vz    = s_axis_tdata[163:116];
    assign in_off   = s_axis_tdata[211:164];
    assign in_dx    = s_axis_tdata[229:212];
    assign in_dy    = s_axis_tdata[247:230];
    assign in_dz    = s_axis_tdata[265:248];
    assign in_rin   = s_axis_tdata[313:266];
    assign in_rout  = s_axis_tdata[361:314];

    logic [3:0]            state_reg;
    logic [TOL_W-1:0]      tol_reg;
    logic [PLIM_W-1:0]     plim_reg;
    logic                  neg_tol_reg;
    logic [IDX_W:0]        p_reg;
    logic [IDX_W-1:0]      last_reg;
    vec_t                  vx_reg;
    vec_t                  vy_reg;
    vec_t                  vz_reg;
    nrm_t                  dx_reg;
    nrm_t                  dy_reg;
    nrm_t                  dz_reg;
    vec_t                  rin_reg;
    vec_t                  rout_reg;
    nrm_t                  nx_reg;
    nrm_t                  ny_reg;
    nrm_t                  nz_reg;
    vec_t                  off_reg;
    logic [1:0]            k_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [W_W-1:0] w_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [UD_W-1:0]       ud_reg;
    logic [W_W-1:0]        rem_reg;
    logic [Q_W-1:0]        q_reg;
    logic                  qneg_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  res_hit_reg;
    vec_t                  res_in_reg;
    vec_t                  res_out_reg;
    logic                  m_valid_reg;
    logic [OUT_BYTES_W-1:0] m_data_reg;

    logic in_accept;
    logic out_load;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // The finished result moves to the output register once that is free
    // or being emptied in the same cycle.
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_axis_tready);

    // Plane table: write on an accepted write command, read while walking.
    logic              ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic              first_in_table;
    nrm_t              sat_x;
    nrm_t              sat_y;
    nrm_t              sat_z;

    // Saturate a written normal component to the 18-bit range.
    function automatic nrm_t sat_nrm(input vec_t v);
        nrm_t r;
        if (v > 48'sd131071)
        begin
            r = 18'sd131071;
        end
        else if (v < -48'sd131072)
        begin
            r = -18'sd131072;
        end
        else
        begin
            r = v[NRM_W-1:0];
        end
        return r;
    endfunction

    assign first_in_table = 32'(in_first) < PLANE_COUNT;
    assign sat_x     = sat_nrm(in_vx);
    assign sat_y     = sat_nrm(in_vy);
    assign sat_z     = sat_nrm(in_vz);
    assign ram_we    = in_accept && (in_cmd == CMD_WRITE) && first_in_table;
    assign ram_wdata = {in_off, sat_z, sat_y, sat_x};

    rcpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PLANE_COUNT)
    ) u_plane_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_first)),
        .wdata (ram_wdata),
        .raddr (AW'(p_reg)),
        .rdata (ram_rdata)
    );

    // Dot product step: one start-by-normal and one direction-by-normal
    // product per cycle, the first taken to Q16 by flooring.
    vec_t                    v_sel;
    nrm_t                    n_sel;
    nrm_t                    d_sel;
    logic signed [65:0]      prod_vn;
    logic signed [W_W-1:0]   prod_dn;

    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                v_sel = vx_reg;
                n_sel = nx_reg;
                d_sel = dx_reg;
            end
            2'd1:
            begin
                v_sel = vy_reg;
                n_sel = ny_reg;
                d_sel = dy_reg;
            end
            default:
            begin
                v_sel = vz_reg;
                n_sel = nz_reg;
                d_sel = dz_reg;
            end
        endcase
    end

    assign prod_vn = v_sel * n_sel;
    assign prod_dn = d_sel * n_sel;

    // Plane tests on the finished dot products.
    logic signed [D_W-1:0]  d_val;
    logic [W_W-1:0]         w_abs;
    logic [W_W-1:0]         plim_q16;
    logic signed [D_W-1:0]  te_val;
    logic [D_W-1:0]         d_abs;

    assign d_val    = D_W'(off_reg) - D_W'(acc_reg);
    assign w_abs    = w_reg[W_W-1] ? W_W'(-w_reg) : W_W'(w_reg);
    assign plim_q16 = W_W'({plim_reg, 16'b0});
    assign te_val   = neg_tol_reg ? -D_W'($signed({1'b0, tol_reg}))
                                  : D_W'($signed({1'b0, tol_reg}));
    assign d_abs    = d_val[D_W-1] ? D_W'(-d_val) : D_W'(d_val);

    // Restoring divide step, one quotient bit per cycle, saturating at 2^47.
    logic [W_W:0]   rem_sh;
    logic           rem_ge;
    logic [Q_W-1:0] q_sh;

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge = rem_sh >= (W_W+1)'(ud_reg);
    assign q_sh   = {q_reg[Q_W-2:0], rem_ge};

    // Signed, saturated plane distance.
    vec_t s_val;
    assign s_val = qneg_reg ? VEC_W'(-$signed(q_reg))
                 : (q_reg >= QUOT_CAP ? VEC_W'(QUOT_CAP - Q_W'(1)) : VEC_W'(q_reg));

    // Interval emptiness test.
    logic signed [VEC_W+2:0] rin_tol;
    logic signed [VEC_W+2:0] tol_ext;
    logic                    empty;

    assign tol_ext = (VEC_W+3)'($signed({1'b0, tol_reg}));
    assign rin_tol = (VEC_W+3)'(rin_reg) + tol_ext;
    assign empty   = (rin_tol >= (VEC_W+3)'(rout_reg))
                  || ((VEC_W+3)'(rout_reg) <= tol_ext);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg  <= TOL_W'(66);
            plim_reg <= PLIM_W'(66);
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_TOLERANCE)
            begin
                tol_reg <= cfg_data;
            end
            else if (cfg_index == CFG_PAR_LIMIT)
            begin
                plim_reg <= cfg_data[PLIM_W-1:0];
            end
        end
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (in_cmd == CMD_SHOOT || in_cmd == CMD_SHOOT_NEG)
                        begin
                            state_reg <= ST_START;
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_START:
                begin
                    if (p_reg > (IDX_W+1)'(last_reg))
                    begin
                        state_reg <= ST_FIN;
                    end
                    else if (32'(p_reg) < PLANE_COUNT)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    if (w_abs > plim_q16)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else if (d_val > te_val)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_TEST;
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == CNT_W'(NUM_W - 1))
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    state_reg <= ST_TEST;
                end
                ST_TEST:
                begin
                    if (empty)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_START;
                    end
                end
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                p_reg       <= (IDX_W+1)'(in_first);
                last_reg    <= in_last;
                neg_tol_reg <= (in_cmd == CMD_SHOOT_NEG);
                vx_reg      <= in_vx;
                vy_reg      <= in_vy;
                vz_reg      <= in_vz;
                dx_reg      <= in_dx;
                dy_reg      <= in_dy;
                dz_reg      <= in_dz;
                rin_reg     <= in_rin;
                rout_reg    <= in_rout;
                res_hit_reg <= (in_cmd == CMD_WRITE);
                res_in_reg  <= '0;
                res_out_reg <= '0;
            end
            ST_START:
            begin
                if (p_reg > (IDX_W+1)'(last_reg))
                begin
                    // Every plane passed: the interval survives.
                    res_hit_reg <= 1'b1;
                    res_in_reg  <= rin_reg[VEC_W-1] ? '0 : rin_reg;
                    res_out_reg <= rout_reg;
                end
                else if (32'(p_reg) >= PLANE_COUNT)
                begin
                    p_reg <= p_reg + 1'b1;
                end
            end
            ST_LOAD:
            begin
                nx_reg  <= ram_rdata[NRM_W-1:0];
                ny_reg  <= ram_rdata[2*NRM_W-1:NRM_W];
                nz_reg  <= ram_rdata[3*NRM_W-1:2*NRM_W];
                off_reg <= ram_rdata[ENTRY_W-1:3*NRM_W];
                k_reg   <= 2'd0;
                acc_reg <= '0;
                w_reg   <= '0;
            end
            ST_MUL:
            begin
                acc_reg <= acc_reg + ACC_W'(prod_vn >>> 16);
                w_reg   <= w_reg + prod_dn;
                k_reg   <= k_reg + 2'd1;
            end
            ST_CHK:
            begin
                qneg_reg <= d_val[D_W-1] != w_reg[W_W-1];
                num_reg  <= {d_abs, 32'b0};
                ud_reg   <= w_abs[UD_W-1:0];
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= '0;
                res_hit_reg <= 1'b0;
                res_in_reg  <= '0;
                res_out_reg <= '0;
            end
            ST_DIV:
            begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                rem_reg <= rem_ge ? W_W'(rem_sh - (W_W+1)'(ud_reg)) : W_W'(rem_sh);
                q_reg   <= (q_sh > QUOT_CAP) ? QUOT_CAP : q_sh;
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_UPD:
            begin
                if (!w_reg[W_W-1])
                begin
                    if (s_val > rin_reg)
                    begin
                        rin_reg <= s_val;
                    end
                end
                else if (s_val < rout_reg)
                begin
                    rout_reg <= s_val;
                end
            end
            ST_TEST:
            begin
                p_reg <= p_reg + 1'b1;
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    m_data_reg <= OUT_BYTES_W'({res_out_reg, res_in_reg, res_hit_reg});
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* tb/sv/ray_convex_polyhedron_clip_tb.sv */
// Self-checking testbench for the ray clip against a convex polyhedron of planes.
`timescale 1ns / 100ps

module ray_convex_polyhedron_clip_tb;
    import rcpc_pkg::*;

    // One command item, in the order in which the fields sit in tdata.
    typedef struct {
        logic [1:0]        cmd;
        logic [8:0]        first_index;
        logic [8:0]        last_index;
        logic signed [47:0] vec_x;
        logic signed [47:0] vec_y;
        logic signed [47:0] vec_z;
        logic signed [47:0] plane_offset;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic signed [17:0] dir_z;
        logic signed [47:0] range_in;
        logic signed [47:0] range_out;
    } clip_cmd_t;

    // One result item: hit flag and the clipped interval.
    typedef struct {
        logic               hit;
        logic signed [47:0] enter_dist;
        logic signed [47:0] exit_dist;
    } clip_res_t;

    // The scoreboard keeps its own plane table and register copies, works out
    // the clipped interval for every accepted command and checks the results
    // in order against it.
    class clip_scoreboard;
        longint    nrm_x [512];
        longint    nrm_y [512];
        longint    nrm_z [512];
        longint    offs [512];
        longint    tol_reg;
        longint    plim_reg;
        clip_res_t pending_q[$];
        int        error_count;
        int        shoot_count;
        int        hit_count;
        int        write_count;

        function new();
            tol_reg = 66;
            plim_reg = 66;
            error_count = 0;
            shoot_count = 0;
            hit_count = 0;
            write_count = 0;
        endfunction

        function void set_register(logic idx, longint value);
            if (idx == CFG_TOLERANCE)
                tol_reg = value & 64'hFFFF_FFFF;
            else
                plim_reg = value & 64'h1_FFFF;
        endfunction

        // floor(p * n / 2^16) done in two halves so nothing overflows.
        function longint mul_q16(longint p, longint n);
            longint ph;
            longint pl;
            ph = p >>> 16;
            pl = p - ph * 65536;
            return ph * n + ((pl * n) >>> 16);
        endfunction

        // d * 2^32 / w, truncated towards zero and saturated to 48 bits.
        function longint plane_distance(longint num, longint den);
            logic        neg;
            logic [63:0] an;
            logic [63:0] ad;
            logic [127:0] q;
            logic [127:0] cap;
            neg = (num < 0) != (den < 0);
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            cap = 128'd1 << 47;
            q = ({64'd0, an} << 32) / {64'd0, ad};
            if (q > cap)
                q = cap;
            if (neg)
                return -longint'(q[63:0]);
            return (q >= cap) ? longint'(cap[63:0]) - 1 : longint'(q[63:0]);
        endfunction

        function longint clamp_normal(longint v);
            return (v < -131072) ? -131072 : ((v > 131071) ? 131071 : v);
        endfunction

        function clip_res_t clip_ray(clip_cmd_t c);
            clip_res_t r;
            longint    rin;
            longint    rout;
            longint    te;
            longint    plim;
            longint    d;
            longint    w;
            longint    s;
            int        p;
            r.hit = 1'b0;
            r.enter_dist = '0;
            r.exit_dist = '0;
            if (c.cmd == CMD_WRITE) begin
                nrm_x[c.first_index] = clamp_normal(longint'(c.vec_x));
                nrm_y[c.first_index] = clamp_normal(longint'(c.vec_y));
                nrm_z[c.first_index] = clamp_normal(longint'(c.vec_z));
                offs[c.first_index] = longint'(c.plane_offset);
                r.hit = 1'b1;
                write_count++;
                return r;
            end
            if (c.cmd == CMD_NONE)
                return r;
            shoot_count++;
            rin = longint'(c.range_in);
            rout = longint'(c.range_out);
            te = (c.cmd == CMD_SHOOT_NEG) ? -tol_reg : tol_reg;
            plim = plim_reg * 65536;
            for (p = c.first_index; p <= c.last_index; p++) begin
                d = offs[p] - (mul_q16(c.vec_x, nrm_x[p]) + mul_q16(c.vec_y, nrm_y[p])
                               + mul_q16(c.vec_z, nrm_z[p]));
                w = longint'(c.dir_x) * nrm_x[p] + longint'(c.dir_y) * nrm_y[p]
                    + longint'(c.dir_z) * nrm_z[p];
                if (w < -plim || w > plim) begin
                    s = plane_distance(d, w);
                    if (w > 0) begin
                        if (s > rin)
                            rin = s;
                    end
                    else if (s < rout) begin
                        rout = s;
                    end
                end
                else if (d > te) begin
                    return r;
                end
                if (rin + tol_reg >= rout || rout <= tol_reg)
                    return r;
            end
            if (rin < 0)
                rin = 0;
            r.hit = 1'b1;
            r.enter_dist = rin[47:0];
            r.exit_dist = rout[47:0];
            hit_count++;
            return r;
        endfunction

        function void note_command(clip_cmd_t c);
            pending_q.push_back(clip_ray(c));
        endfunction

        function void check_result(logic [OUT_BYTES_W-1:0] data);
            clip_res_t e;
            if (pending_q.size() == 0) begin
                $error("result item with no command outstanding: %h", data);
                error_count++;
                return;
            end
            e = pending_q.pop_front();
            if (data[0] !== e.hit) begin
                $error("hit: expected %0d, got %0d", e.hit, data[0]);
                error_count++;
            end
            if (data[48:1] !== e.enter_dist) begin
                $error("enter_dist: expected %0d, got %0d", e.enter_dist,
                       $signed(data[48:1]));
                error_count++;
            end
            if (data[96:49] !== e.exit_dist) begin
                $error("exit_dist: expected %0d, got %0d", e.exit_dist,
                       $signed(data[96:49]));
                error_count++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_BYTES_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;
    logic                   cfg_wr_en;
    logic                   cfg_index;
    logic [TOL_W-1:0]       cfg_data;

    clip_scoreboard sb;
    bit             written [512];
    logic           hold_off;       // receiver held off completely
    logic           hold_request;   // asks the hold-off process for one long stretch
    int             ready_mode;
    int             burst_left;
    logic           gaps_enabled;

    ray_convex_polyhedron_clip dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result side. Results are sampled at the rising edge, before the block
    // updates, and tready follows a pattern that is switched at random:
    // always ready, ready about half the time, or mostly stalled.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if ($urandom_range(0, 47) == 0)
            ready_mode <= $urandom_range(0, 2);
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (ready_mode == 0)
            m_axis_tready <= 1'b1;
        else if (ready_mode == 1)
            m_axis_tready <= 1'($urandom_range(0, 1));
        else
            m_axis_tready <= ($urandom_range(0, 5) == 0);
    end

    // Long receiver hold-off, counted here so that the sender keeps offering
    // items meanwhile; the block has to fill up and drop s_axis_tready.
    initial
    begin
        hold_off = 1'b0;
        wait (hold_request === 1'b1);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (800) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Generous overall limit; a correct run takes a small fraction of this.
    initial
    begin
        #200000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offers one item and returns at the edge at which it is accepted. Valid
    // stays high into the next call so back-to-back items form a burst.
    task automatic send_cmd(clip_cmd_t c);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, c.range_out, c.range_in, c.dir_z, c.dir_y, c.dir_x,
                         c.plane_offset, c.vec_z, c.vec_y, c.vec_x,
                         c.last_index, c.first_index, c.cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_command(c);
        if (c.cmd == CMD_WRITE)
            written[c.first_index] = 1'b1;
        // Bursts of random length separated by random gaps.
        if (burst_left > 0) begin
            burst_left--;
        end
        else if (gaps_enabled) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // Lets every outstanding result arrive, then allows a short settling time.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(logic idx, longint value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[31:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_register(idx, value);
    endtask

    function automatic clip_cmd_t blank_cmd(logic [1:0] code);
        clip_cmd_t c;
        c.cmd = code;
        c.first_index = '0;
        c.last_index = '0;
        c.vec_x = '0;
        c.vec_y = '0;
        c.vec_z = '0;
        c.plane_offset = '0;
        c.dir_x = '0;
        c.dir_y = '0;
        c.dir_z = '0;
        c.range_in = '0;
        c.range_out = '0;
        return c;
    endfunction

    function automatic clip_cmd_t plane_cmd(int idx, longint nx, longint ny, longint nz,
                                            longint off);
        clip_cmd_t c;
        c = blank_cmd(CMD_WRITE);
        c.first_index = 9'(idx);
        c.vec_x = 48'(nx);
        c.vec_y = 48'(ny);
        c.vec_z = 48'(nz);
        c.plane_offset = 48'(off);
        return c;
    endfunction

    function automatic clip_cmd_t ray_cmd(logic [1:0] code, int first, int last,
                                          longint px, longint py, longint pz,
                                          longint dx, longint dy, longint dz,
                                          longint rin, longint rout);
        clip_cmd_t c;
        c = blank_cmd(code);
        c.first_index = 9'(first);
        c.last_index = 9'(last);
        c.vec_x = 48'(px);
        c.vec_y = 48'(py);
        c.vec_z = 48'(pz);
        c.dir_x = 18'(dx);
        c.dir_y = 18'(dy);
        c.dir_z = 18'(dz);
        c.range_in = 48'(rin);
        c.range_out = 48'(rout);
        return c;
    endfunction

    function automatic longint rand48();
        return {$urandom(), $urandom()} & 64'hFFFF_FFFF_FFFF;
    endfunction

    function automatic longint rand_sext48();
        longint v;
        v = rand48();
        return (v >= 64'sh8000_0000_0000) ? v - 64'sh1_0000_0000_0000 : v;
    endfunction

    function automatic longint rand_dir();
        return longint'($urandom_range(0, 131072)) - 65536;
    endfunction

    // Random plane: mostly a plausible face of a solid near the origin, now and
    // then full-width noise that exercises normal saturation.
    function automatic clip_cmd_t random_plane();
        int     idx;
        longint ax;
        idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 63);
        if ($urandom_range(0, 4) == 0)
            return plane_cmd(idx, rand_sext48(), rand_sext48(), rand_sext48(), rand_sext48());
        if ($urandom_range(0, 1) == 0) begin
            ax = $urandom_range(0, 1) ? 65536 : -65536;
            case ($urandom_range(0, 2))
                0: return plane_cmd(idx, ax, 0, 0, longint'($urandom_range(0, 1 << 22)));
                1: return plane_cmd(idx, 0, ax, 0, longint'($urandom_range(0, 1 << 22)));
                default: return plane_cmd(idx, 0, 0, ax, longint'($urandom_range(0, 1 << 22)));
            endcase
        end
        return plane_cmd(idx, rand_dir(), rand_dir(), rand_dir(),
                         longint'($urandom_range(0, 1 << 24)) - (1 << 22));
    endfunction

    // Random shoot over a short run of written planes, or occasionally an
    // empty range, with a start point near the origin or anywhere at all.
    function automatic clip_cmd_t random_shoot();
        clip_cmd_t c;
        int        first;
        int        last;
        int        span;
        logic [1:0] code;
        code = $urandom_range(0, 1) ? CMD_SHOOT : CMD_SHOOT_NEG;
        if ($urandom_range(0, 9) == 0) begin
            first = $urandom_range(1, 511);
            last = $urandom_range(0, first - 1);
        end
        else begin
            do
                first = $urandom_range(0, 63);
            while (!written[first]);
            span = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(0, 3);
            last = first;
            while (last < 511 && span > 0 && written[last + 1]) begin
                last++;
                span--;
            end
        end
        c = ray_cmd(code, first, last,
                    longint'($urandom_range(0, 1 << 21)) - (1 << 20),
                    longint'($urandom_range(0, 1 << 21)) - (1 << 20),
                    longint'($urandom_range(0, 1 << 21)) - (1 << 20),
                    rand_dir(), rand_dir(), rand_dir(),
                    -longint'($urandom_range(0, 1 << 26)),
                    longint'($urandom_range(0, 1 << 30)));
        if ($urandom_range(0, 5) == 0) begin
            c.vec_x = 48'(rand_sext48());
            c.vec_y = 48'(rand_sext48());
            c.vec_z = 48'(rand_sext48());
            c.plane_offset = 48'(rand_sext48());
            c.range_in = 48'(rand_sext48());
            c.range_out = 48'(rand_sext48());
        end
        return c;
    endfunction

    task automatic random_items(int count);
        clip_cmd_t c;
        int        i;
        for (i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: c = random_plane();
                6: begin
                    c = random_shoot();
                    c.cmd = CMD_NONE;
                end
                default: c = random_shoot();
            endcase
            send_cmd(c);
        end
    endtask

    initial
    begin
        int i;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_TOLERANCE;
        cfg_data = '0;
        hold_request = 1'b0;
        ready_mode = 0;
        burst_left = 0;
        gaps_enabled = 1'b1;
        for (i = 0; i < 512; i++)
            written[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset values of the registers: a unit cube of
        // six axis planes, extreme and saturating normals, the top table entry.
        send_cmd(plane_cmd(0, 65536, 0, 0, 65536));
        send_cmd(plane_cmd(1, -65536, 0, 0, 65536));
        send_cmd(plane_cmd(2, 0, 65536, 0, 65536));
        send_cmd(plane_cmd(3, 0, -65536, 0, 65536));
        send_cmd(plane_cmd(4, 0, 0, 65536, 65536));
        send_cmd(plane_cmd(5, 0, 0, -65536, 65536));
        // Normals far outside the stored width saturate on the way in.
        send_cmd(plane_cmd(6, 64'sh7FFF_FFFF_FFFF, -64'sh8000_0000_0000, 131071,
                           64'sh7FFF_FFFF_FFFF));
        send_cmd(plane_cmd(7, -131072, 1, -1, -64'sh8000_0000_0000));
        send_cmd(plane_cmd(511, 0, 0, 0, 0));
        // Ray along x from the centre, through the cube: both shoot kinds.
        send_cmd(ray_cmd(CMD_SHOOT, 0, 5, 0, 0, 0, 65536, 0, 0, -(1 << 30), 1 << 30));
        send_cmd(ray_cmd(CMD_SHOOT_NEG, 0, 5, 0, 0, 0, -65536, 0, 0, -(1 << 30), 1 << 30));
        // Ray parallel to the y planes but outside them: rejected there.
        send_cmd(ray_cmd(CMD_SHOOT, 2, 3, 0, 5 << 16, 0, 65536, 0, 0, 0, 1 << 30));
        // Start point exactly on a parallel plane: the negated tolerance differs.
        send_cmd(ray_cmd(CMD_SHOOT_NEG, 2, 2, 0, 65536, 0, 0, 0, 65536, 0, 1 << 30));
        send_cmd(ray_cmd(CMD_SHOOT, 2, 2, 0, 65536, 0, 0, 0, 65536, 0, 1 << 30));
        // Empty plane range keeps the starting interval, entry clamped at zero.
        send_cmd(ray_cmd(CMD_SHOOT, 511, 0, 0, 0, 0, 0, 0, 0,
                         -64'sh8000_0000_0000, 64'sh7FFF_FFFF_FFFF));
        // Saturating plane distances, extreme directions and start points.
        send_cmd(ray_cmd(CMD_SHOOT, 6, 7, 64'sh7FFF_FFFF_FFFF, -64'sh8000_0000_0000,
                         64'sh7FFF_FFFF_FFFF, 65536, -65536, 65536,
                         -64'sh8000_0000_0000, 64'sh7FFF_FFFF_FFFF));
        send_cmd(ray_cmd(CMD_SHOOT_NEG, 0, 511, 0, 0, 0, -65536, 65536, -65536, 0, 1 << 20));
        send_cmd(ray_cmd(CMD_SHOOT, 511, 511, 0, 0, 0, 1, 1, 1, 0, 1 << 20));
        // Unused command: no effect, a miss.
        send_cmd(ray_cmd(CMD_NONE, 3, 1, 5, 6, 7, 1, 2, 3, 4, 5));
        drain();

        // Random phases, each under its own register setting.
        write_register(CFG_TOLERANCE, 66);
        write_register(CFG_PAR_LIMIT, 66);
        random_items(200);
        drain();

        // Zero tolerance and threshold; the receiver holds off for a long
        // stretch while the sender keeps offering items.
        write_register(CFG_TOLERANCE, 0);
        write_register(CFG_PAR_LIMIT, 0);
        hold_request = 1'b1;
        random_items(200);
        drain();

        // Largest tolerance and a large threshold: almost every plane counts as parallel.
        write_register(CFG_TOLERANCE, 64'hFFFF_FFFF);
        write_register(CFG_PAR_LIMIT, 65536);
        random_items(150);
        drain();

        // Gapless sender with a moderate setting.
        write_register(CFG_TOLERANCE, 655);
        write_register(CFG_PAR_LIMIT, 6553);
        gaps_enabled = 1'b0;
        random_items(200);
        drain();

        // Random register values.
        gaps_enabled = 1'b1;
        write_register(CFG_TOLERANCE, {$urandom()} % (1 << 20));
        write_register(CFG_PAR_LIMIT, $urandom_range(0, 65536));
        random_items(200);
        drain();

        $display("Covered %0d plane writes and %0d shoots, %0d of them hits.",
                 sb.write_count, sb.shoot_count, sb.hit_count);
        $display("Five register settings, a long receiver stall and bursty input.");
        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
